// ===== src/ane_pkg.sv =====
`default_nettype none

package ane_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE      = 2'd0,
    CMD_FIELD_END = 2'd1,
    CMD_DECIDE    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CODING_IDENTITY = 2'd0,
    CODING_GZIP     = 2'd1,
    CODING_NONE     = 2'd2
  } coding_e;

  typedef enum logic [3:0] {
    PH_COD_LEAD  = 4'b0001,
    PH_COD_BODY  = 4'b0010,
    PH_COD_TRAIL = 4'b0100,
    PH_PARAMS    = 4'b1000
  } item_phase_e;

  typedef enum logic [9:0] {
    PP_LEAD        = 10'b00_0000_0001,
    PP_Q           = 10'b00_0000_0010,
    PP_NAME_TRAIL  = 10'b00_0000_0100,
    PP_V_LEAD      = 10'b00_0000_1000,
    PP_V_ONE       = 10'b00_0001_0000,
    PP_V_ONE_FRAC  = 10'b00_0010_0000,
    PP_V_ZERO      = 10'b00_0100_0000,
    PP_V_ZERO_FRAC = 10'b00_1000_0000,
    PP_V_TRAIL     = 10'b01_0000_0000,
    PP_SKIP        = 10'b10_0000_0000
  } param_phase_e;

  localparam logic [9:0]  QUALITY_MAX = 10'd1000;
  localparam logic [10:0] BEST_UNSEEN = 11'h7FF;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] coding;
    logic [9:0] gzip_quality;
    logic [9:0] identity_quality;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/accept_encoding_negotiator.sv =====
// A decide transfer shows its result on the output in the cycle after it is accepted.
// Header bytes and field ends produce no result and update the parser registers.
// Throughput: one transfer per cycle; the parser state is a single short step per byte.
// Only a decide transfer meeting a stalled, still-full output register is held back.
// Reset (rst_ni low, asynchronous) clears the parser, the best qualities and the output valid.
`default_nettype none

module accept_encoding_negotiator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ane_pkg::in_item_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ane_pkg::out_item_t    out_data_o
);

  localparam logic [7:0] GZIP_WORD [4] = '{"g", "z", "i", "p"};
  localparam logic [7:0] IDENTITY_WORD [8] = '{"i", "d", "e", "n", "t", "i", "t", "y"};

  logic signed [10:0] gzip_best_q, gzip_best_d;
  logic signed [10:0] identity_best_q, identity_best_d;
  logic signed [10:0] wildcard_best_q, wildcard_best_d;
  logic header_seen_q, header_seen_d;
  ane_pkg::item_phase_e item_phase_q, item_phase_d;
  // Bit 0 kills gzip, bit 1 kills identity, bit 2 kills the wildcard.
  logic [2:0] kill_q, kill_d;
  logic [3:0] coding_len_q, coding_len_d;
  ane_pkg::param_phase_e param_phase_q, param_phase_d;
  logic [9:0] quality_q, quality_d;
  logic [1:0] digit_count_q, digit_count_d;
  logic q_seen_q, q_seen_d;
  logic item_invalid_q, item_invalid_d;
  logic seg_nonempty_q, seg_nonempty_d;
  logic out_valid_q, out_valid_d;
  ane_pkg::out_item_t out_data_q, out_data_d;

  logic       in_accept;
  logic [7:0] c;
  logic [7:0] lc;
  logic       ws;
  logic       end_invalid;
  logic [9:0] end_quality;
  logic signed [10:0] end_q_s;
  logic       gzip_hit, identity_hit, wildcard_hit;
  logic [9:0] g_eff, i_eff;
  logic [1:0] choice;
  logic [9:0] frac_add;
  logic [3:0] digit;

  function automatic logic seg_bad(input ane_pkg::param_phase_e pp, input logic nonempty,
                                   input logic trailing);
    logic bad;
    bad = 1'b0;
    if (pp == ane_pkg::PP_LEAD) begin
      bad = !trailing || nonempty;
    end else if (pp == ane_pkg::PP_Q || pp == ane_pkg::PP_NAME_TRAIL ||
                 pp == ane_pkg::PP_V_LEAD) begin
      bad = 1'b1;
    end
    return bad;
  endfunction

  assign in_stall_o = out_valid_q && out_stall_i &&
                      (in_data_i.command == ane_pkg::CMD_DECIDE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign c          = in_data_i.data_byte;
  assign lc         = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign ws         = (c == " ") || (c == 8'h09);
  assign digit      = c[3:0];

  always_comb begin
    case (digit_count_q)
      2'd0:    frac_add = 10'(digit) * 10'd100;
      2'd1:    frac_add = 10'(digit) * 10'd10;
      default: frac_add = 10'(digit);
    endcase
  end

  // Outcome of closing the current item, used by a comma and by a field end.
  assign end_invalid = item_invalid_q ||
                       (item_phase_q == ane_pkg::PH_PARAMS &&
                        seg_bad(param_phase_q, seg_nonempty_q, 1'b1));
  assign end_quality  = end_invalid ? 10'd0 : quality_q;
  assign end_q_s      = $signed({1'b0, end_quality});
  assign gzip_hit     = !kill_q[0] && coding_len_q == 4'd4;
  assign identity_hit = !gzip_hit && !kill_q[1] && coding_len_q == 4'd8;
  assign wildcard_hit = !gzip_hit && !identity_hit && !kill_q[2] && coding_len_q == 4'd1;

  // Effective qualities with wildcard defaults at request end.
  always_comb begin
    if (!gzip_best_q[10]) begin
      g_eff = gzip_best_q[9:0];
    end else if (!wildcard_best_q[10] && wildcard_best_q != 11'sd0) begin
      g_eff = wildcard_best_q[9:0];
    end else begin
      g_eff = 10'd0;
    end
    if (!identity_best_q[10]) begin
      i_eff = identity_best_q[9:0];
    end else if (wildcard_best_q == 11'sd0) begin
      i_eff = 10'd0;
    end else begin
      i_eff = ane_pkg::QUALITY_MAX;
    end
    if (!header_seen_q) begin
      choice = ane_pkg::CODING_IDENTITY;
    end else if (g_eff == 10'd0 && i_eff == 10'd0) begin
      choice = ane_pkg::CODING_NONE;
    end else if (g_eff != 10'd0 && g_eff >= i_eff) begin
      choice = ane_pkg::CODING_GZIP;
    end else begin
      choice = ane_pkg::CODING_IDENTITY;
    end
  end

  always_comb begin
    logic clear_item;
    logic clear_all;
    logic end_item;
    logic take_eq;
    logic bad;
    logic code_char;

    gzip_best_d     = gzip_best_q;
    identity_best_d = identity_best_q;
    wildcard_best_d = wildcard_best_q;
    header_seen_d   = header_seen_q;
    item_phase_d    = item_phase_q;
    kill_d          = kill_q;
    coding_len_d    = coding_len_q;
    param_phase_d   = param_phase_q;
    quality_d       = quality_q;
    digit_count_d   = digit_count_q;
    q_seen_d        = q_seen_q;
    item_invalid_d  = item_invalid_q;
    seg_nonempty_d  = seg_nonempty_q;
    out_data_d      = out_data_q;
    out_valid_d     = out_valid_q && out_stall_i;
    clear_item      = 1'b0;
    clear_all       = 1'b0;
    end_item        = 1'b0;
    take_eq         = 1'b0;
    bad             = 1'b0;
    code_char       = 1'b0;

    if (in_accept) begin
      case (in_data_i.command)
        ane_pkg::CMD_BYTE: begin
          if (c == ",") begin
            end_item = 1'b1;
          end else begin
            case (item_phase_q)
              ane_pkg::PH_COD_LEAD: begin
                if (c == ";") begin
                  item_phase_d   = ane_pkg::PH_PARAMS;
                  param_phase_d  = ane_pkg::PP_LEAD;
                  seg_nonempty_d = 1'b0;
                end else if (!ws) begin
                  code_char    = 1'b1;
                  item_phase_d = ane_pkg::PH_COD_BODY;
                end
              end
              ane_pkg::PH_COD_BODY: begin
                if (ws) begin
                  item_phase_d = ane_pkg::PH_COD_TRAIL;
                end else if (c == ";") begin
                  item_phase_d   = ane_pkg::PH_PARAMS;
                  param_phase_d  = ane_pkg::PP_LEAD;
                  seg_nonempty_d = 1'b0;
                end else begin
                  code_char = 1'b1;
                end
              end
              ane_pkg::PH_COD_TRAIL: begin
                if (c == ";") begin
                  item_phase_d   = ane_pkg::PH_PARAMS;
                  param_phase_d  = ane_pkg::PP_LEAD;
                  seg_nonempty_d = 1'b0;
                end else if (!ws) begin
                  // A second word after whitespace can match nothing.
                  kill_d       = 3'b111;
                  code_char    = 1'b1;
                  item_phase_d = ane_pkg::PH_COD_BODY;
                end
              end
              default: begin
                if (c == ";") begin
                  if (seg_bad(param_phase_q, seg_nonempty_q, 1'b0)) begin
                    item_invalid_d = 1'b1;
                  end
                  param_phase_d  = ane_pkg::PP_LEAD;
                  seg_nonempty_d = 1'b0;
                end else begin
                  case (param_phase_q)
                    ane_pkg::PP_LEAD: begin
                      if (!ws) begin
                        seg_nonempty_d = 1'b1;
                        if (lc == "q") begin
                          param_phase_d = ane_pkg::PP_Q;
                        end else begin
                          bad = 1'b1;
                        end
                      end
                    end
                    ane_pkg::PP_Q: begin
                      if (c == "=") begin
                        take_eq = 1'b1;
                      end else if (ws) begin
                        param_phase_d = ane_pkg::PP_NAME_TRAIL;
                      end else begin
                        bad = 1'b1;
                      end
                    end
                    ane_pkg::PP_NAME_TRAIL: begin
                      if (c == "=") begin
                        take_eq = 1'b1;
                      end else if (!ws) begin
                        bad = 1'b1;
                      end
                    end
                    ane_pkg::PP_V_LEAD: begin
                      if (c == "1") begin
                        quality_d     = ane_pkg::QUALITY_MAX;
                        param_phase_d = ane_pkg::PP_V_ONE;
                      end else if (c == "0") begin
                        quality_d     = 10'd0;
                        param_phase_d = ane_pkg::PP_V_ZERO;
                      end else if (!ws) begin
                        bad = 1'b1;
                      end
                    end
                    ane_pkg::PP_V_ONE, ane_pkg::PP_V_ZERO: begin
                      if (c == ".") begin
                        digit_count_d = 2'd0;
                        param_phase_d = (param_phase_q == ane_pkg::PP_V_ONE) ?
                                        ane_pkg::PP_V_ONE_FRAC : ane_pkg::PP_V_ZERO_FRAC;
                      end else if (ws) begin
                        param_phase_d = ane_pkg::PP_V_TRAIL;
                      end else begin
                        bad = 1'b1;
                      end
                    end
                    ane_pkg::PP_V_ONE_FRAC: begin
                      if (c == "0" && digit_count_q != 2'd3) begin
                        digit_count_d = digit_count_q + 2'd1;
                      end else if (ws) begin
                        param_phase_d = ane_pkg::PP_V_TRAIL;
                      end else begin
                        bad = 1'b1;
                      end
                    end
                    ane_pkg::PP_V_ZERO_FRAC: begin
                      if (c >= "0" && c <= "9" && digit_count_q != 2'd3) begin
                        quality_d     = quality_q + frac_add;
                        digit_count_d = digit_count_q + 2'd1;
                      end else if (ws) begin
                        param_phase_d = ane_pkg::PP_V_TRAIL;
                      end else begin
                        bad = 1'b1;
                      end
                    end
                    ane_pkg::PP_V_TRAIL: begin
                      if (!ws) begin
                        bad = 1'b1;
                      end
                    end
                    default: begin
                    end
                  endcase
                end
              end
            endcase
          end
        end
        ane_pkg::CMD_FIELD_END: begin
          end_item      = 1'b1;
          header_seen_d = 1'b1;
        end
        ane_pkg::CMD_DECIDE: begin
          out_valid_d                 = 1'b1;
          out_data_d.coding           = choice;
          out_data_d.gzip_quality     = g_eff;
          out_data_d.identity_quality = i_eff;
          clear_all                   = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (take_eq) begin
      if (q_seen_q) begin
        bad = 1'b1;
      end else begin
        q_seen_d      = 1'b1;
        digit_count_d = 2'd0;
        param_phase_d = ane_pkg::PP_V_LEAD;
      end
    end
    if (bad) begin
      item_invalid_d = 1'b1;
      param_phase_d  = ane_pkg::PP_SKIP;
    end

    if (code_char) begin
      if (coding_len_q >= 4'd4 || lc != GZIP_WORD[coding_len_q[1:0]]) begin
        kill_d[0] = 1'b1;
      end
      if (coding_len_q >= 4'd8 || lc != IDENTITY_WORD[coding_len_q[2:0]]) begin
        kill_d[1] = 1'b1;
      end
      if (coding_len_q != 4'd0 || c != "*") begin
        kill_d[2] = 1'b1;
      end
      if (coding_len_q != 4'hF) begin
        coding_len_d = coding_len_q + 4'd1;
      end
    end

    if (end_item) begin
      if (gzip_hit && end_q_s > gzip_best_q) begin
        gzip_best_d = end_q_s;
      end
      if (identity_hit && end_q_s > identity_best_q) begin
        identity_best_d = end_q_s;
      end
      if (wildcard_hit && end_q_s > wildcard_best_q) begin
        wildcard_best_d = end_q_s;
      end
      clear_item = 1'b1;
    end

    if (clear_all) begin
      gzip_best_d     = ane_pkg::BEST_UNSEEN;
      identity_best_d = ane_pkg::BEST_UNSEEN;
      wildcard_best_d = ane_pkg::BEST_UNSEEN;
      header_seen_d   = 1'b0;
      clear_item      = 1'b1;
    end

    if (clear_item) begin
      item_phase_d   = ane_pkg::PH_COD_LEAD;
      kill_d         = 3'b000;
      coding_len_d   = 4'd0;
      param_phase_d  = ane_pkg::PP_LEAD;
      quality_d      = ane_pkg::QUALITY_MAX;
      digit_count_d  = 2'd0;
      q_seen_d       = 1'b0;
      item_invalid_d = 1'b0;
      seg_nonempty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gzip_best_q     <= ane_pkg::BEST_UNSEEN;
      identity_best_q <= ane_pkg::BEST_UNSEEN;
      wildcard_best_q <= ane_pkg::BEST_UNSEEN;
      header_seen_q   <= 1'b0;
      item_phase_q    <= ane_pkg::PH_COD_LEAD;
      kill_q          <= 3'b000;
      coding_len_q    <= 4'd0;
      param_phase_q   <= ane_pkg::PP_LEAD;
      quality_q       <= ane_pkg::QUALITY_MAX;
      digit_count_q   <= 2'd0;
      q_seen_q        <= 1'b0;
      item_invalid_q  <= 1'b0;
      seg_nonempty_q  <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      gzip_best_q     <= gzip_best_d;
      identity_best_q <= identity_best_d;
      wildcard_best_q <= wildcard_best_d;
      header_seen_q   <= header_seen_d;
      item_phase_q    <= item_phase_d;
      kill_q          <= kill_d;
      coding_len_q    <= coding_len_d;
      param_phase_q   <= param_phase_d;
      quality_q       <= quality_d;
      digit_count_q   <= digit_count_d;
      q_seen_q        <= q_seen_d;
      item_invalid_q  <= item_invalid_d;
      seg_nonempty_q  <= seg_nonempty_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== src/ane_checker.sv =====
`default_nettype none

module ane_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire ane_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire ane_pkg::out_item_t out_data_o
);

  logic in_acc;
  logic decide_acc;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign decide_acc = in_acc && (in_data_i.command == ane_pkg::CMD_DECIDE);

  // Every decide transfer produces a result in the next cycle.
  a_decide_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decide_acc |=> out_valid_o)
    else $error("decide transfer produced no result");

  // Bytes and field ends never create a result out of nothing.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !decide_acc) |=> !out_valid_o)
    else $error("result appeared without a decide transfer");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or vanished");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.coding <= ane_pkg::CODING_NONE &&
                     out_data_o.gzip_quality <= ane_pkg::QUALITY_MAX &&
                     out_data_o.identity_quality <= ane_pkg::QUALITY_MAX))
    else $error("result field out of range");

  // A decide right after a decide sees the cleared state: identity at full quality.
  a_decide_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide_acc && $past(decide_acc)) |=>
      (out_data_o.coding == ane_pkg::CODING_IDENTITY &&
       out_data_o.gzip_quality == 10'd0 &&
       out_data_o.identity_quality == ane_pkg::QUALITY_MAX))
    else $error("state not cleared after decide");

endmodule

bind accept_encoding_negotiator ane_checker u_ane_checker (.*);

`default_nettype wire

// ===== sim/tb_accept_encoding_negotiator.sv =====
`timescale 1ns / 1ps

module tb_accept_encoding_negotiator;

  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam bit [2:0]    KILL_GZIP     = 3'b001;
  localparam bit [2:0]    KILL_IDENTITY = 3'b010;
  localparam bit [2:0]    KILL_STAR     = 3'b100;
  localparam bit [31:0]   GZIP_WORD     = "gzip";
  localparam bit [63:0]   IDENTITY_WORD = "identity";
  localparam int          HEADER_BYTES  = 1200;
  localparam int          QUIET_LIMIT   = 2000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  ane_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ane_pkg::out_item_t out_data_o;

  int         sender_idle_pct    = 0;
  int         receiver_stall_pct = 0;
  int         bytes_sent         = 0;
  int         quiet_cycles       = 0;
  bit         timed_out          = 1'b0;

  accept_encoding_negotiator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Tracks the header parser and the best quality per coding, and queues the
  // decision that each decide transfer must produce.
  class negotiation_checker;
    bit signed [10:0]      gzip_best;
    bit signed [10:0]      identity_best;
    bit signed [10:0]      wildcard_best;
    bit                    header_seen;
    ane_pkg::item_phase_e  item_phase;
    ane_pkg::param_phase_e param_phase;
    bit [2:0]              killed;
    bit [3:0]              coding_len;
    bit [9:0]              quality;
    bit [1:0]              digit_count;
    bit                    q_seen;
    bit                    item_bad;
    bit                    segment_nonempty;
    ane_pkg::out_item_t    pending_decisions[$];
    int unsigned           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      gzip_best = -11'sd1;
      identity_best = -11'sd1;
      wildcard_best = -11'sd1;
      header_seen = 1'b0;
      clear_item();
    endfunction

    function void clear_item();
      item_phase = ane_pkg::PH_COD_LEAD;
      param_phase = ane_pkg::PP_LEAD;
      killed = '0;
      coding_len = '0;
      quality = ane_pkg::QUALITY_MAX;
      digit_count = '0;
      q_seen = 1'b0;
      item_bad = 1'b0;
      segment_nonempty = 1'b0;
    endfunction

    function bit is_blank(bit [7:0] c);
      return c == " " || c == "\t";
    endfunction

    function void coding_char(bit [7:0] c);
      bit [7:0] lc;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      if (coding_len >= 4 || lc != GZIP_WORD[8 * (3 - coding_len[1:0]) +: 8]) begin
        killed |= KILL_GZIP;
      end
      if (coding_len >= 8 || lc != IDENTITY_WORD[8 * (7 - coding_len[2:0]) +: 8]) begin
        killed |= KILL_IDENTITY;
      end
      // The wildcard is matched exactly and only as a single byte.
      if (coding_len != 0 || c != "*") killed |= KILL_STAR;
      if (coding_len != 4'd15) coding_len++;
    endfunction

    function void bad_param();
      item_bad = 1'b1;
      param_phase = ane_pkg::PP_SKIP;
    endfunction

    // An empty parameter is only forgiven when it is the last one of the item.
    function void close_segment(bit trailing);
      if (param_phase == ane_pkg::PP_LEAD) begin
        if (!trailing || segment_nonempty) item_bad = 1'b1;
      end else if (param_phase == ane_pkg::PP_Q || param_phase == ane_pkg::PP_NAME_TRAIL ||
                   param_phase == ane_pkg::PP_V_LEAD) begin
        item_bad = 1'b1;
      end
    endfunction

    function void take_equals();
      if (q_seen) begin
        bad_param();
      end else begin
        q_seen = 1'b1;
        digit_count = '0;
        param_phase = ane_pkg::PP_V_LEAD;
      end
    endfunction

    function void param_byte(bit [7:0] c);
      bit ws;
      int weight;
      ws = is_blank(c);
      if (c == ";") begin
        close_segment(1'b0);
        param_phase = ane_pkg::PP_LEAD;
        segment_nonempty = 1'b0;
        return;
      end
      case (param_phase)
        ane_pkg::PP_LEAD: begin
          if (!ws) begin
            segment_nonempty = 1'b1;
            if (c == "q" || c == "Q") param_phase = ane_pkg::PP_Q;
            else bad_param();
          end
        end
        ane_pkg::PP_Q: begin
          if (c == "=") take_equals();
          else if (ws) param_phase = ane_pkg::PP_NAME_TRAIL;
          else bad_param();
        end
        ane_pkg::PP_NAME_TRAIL: begin
          if (c == "=") take_equals();
          else if (!ws) bad_param();
        end
        ane_pkg::PP_V_LEAD: begin
          if (c == "1") begin
            quality = ane_pkg::QUALITY_MAX;
            param_phase = ane_pkg::PP_V_ONE;
          end else if (c == "0") begin
            quality = '0;
            param_phase = ane_pkg::PP_V_ZERO;
          end else if (!ws) begin
            bad_param();
          end
        end
        ane_pkg::PP_V_ONE, ane_pkg::PP_V_ZERO: begin
          if (c == ".") begin
            digit_count = '0;
            param_phase = (param_phase == ane_pkg::PP_V_ONE) ?
                          ane_pkg::PP_V_ONE_FRAC : ane_pkg::PP_V_ZERO_FRAC;
          end else if (ws) begin
            param_phase = ane_pkg::PP_V_TRAIL;
          end else begin
            bad_param();
          end
        end
        ane_pkg::PP_V_ONE_FRAC: begin
          if (c == "0" && digit_count < 3) digit_count++;
          else if (ws) param_phase = ane_pkg::PP_V_TRAIL;
          else bad_param();
        end
        ane_pkg::PP_V_ZERO_FRAC: begin
          if (c >= "0" && c <= "9" && digit_count < 3) begin
            weight = (digit_count == 0) ? 100 : (digit_count == 1) ? 10 : 1;
            quality = quality + 10'((int'(c) - int'("0")) * weight);
            digit_count++;
          end else if (ws) begin
            param_phase = ane_pkg::PP_V_TRAIL;
          end else begin
            bad_param();
          end
        end
        ane_pkg::PP_V_TRAIL: begin
          if (!ws) bad_param();
        end
        default: begin
        end
      endcase
    endfunction

    function void end_item();
      bit signed [10:0] q;
      if (item_phase == ane_pkg::PH_PARAMS) close_segment(1'b1);
      q = item_bad ? 11'sd0 : $signed({1'b0, quality});
      if ((killed & KILL_GZIP) == 0 && coding_len == 4) begin
        if (q > gzip_best) gzip_best = q;
      end else if ((killed & KILL_IDENTITY) == 0 && coding_len == 8) begin
        if (q > identity_best) identity_best = q;
      end else if ((killed & KILL_STAR) == 0 && coding_len == 1) begin
        if (q > wildcard_best) wildcard_best = q;
      end
      clear_item();
    endfunction

    function void enter_params();
      item_phase = ane_pkg::PH_PARAMS;
      param_phase = ane_pkg::PP_LEAD;
      segment_nonempty = 1'b0;
    endfunction

    function void header_byte(bit [7:0] c);
      bit ws;
      ws = is_blank(c);
      if (c == ",") begin
        end_item();
        return;
      end
      case (item_phase)
        ane_pkg::PH_COD_LEAD: begin
          if (c == ";") begin
            enter_params();
          end else if (!ws) begin
            coding_char(c);
            item_phase = ane_pkg::PH_COD_BODY;
          end
        end
        ane_pkg::PH_COD_BODY: begin
          if (ws) item_phase = ane_pkg::PH_COD_TRAIL;
          else if (c == ";") enter_params();
          else coding_char(c);
        end
        ane_pkg::PH_COD_TRAIL: begin
          // A second word after blanks spoils the coding.
          if (c == ";") begin
            enter_params();
          end else if (!ws) begin
            killed = KILL_GZIP | KILL_IDENTITY | KILL_STAR;
            coding_char(c);
            item_phase = ane_pkg::PH_COD_BODY;
          end
        end
        default: param_byte(c);
      endcase
    endfunction

    function void absorb_transfer(ane_pkg::in_item_t it);
      bit signed [10:0] g;
      bit signed [10:0] i;
      ane_pkg::out_item_t verdict;
      case (it.command)
        ane_pkg::CMD_BYTE: header_byte(it.data_byte);
        ane_pkg::CMD_FIELD_END: begin
          end_item();
          header_seen = 1'b1;
        end
        ane_pkg::CMD_DECIDE: begin
          g = (gzip_best >= 0) ? gzip_best : (wildcard_best > 0) ? wildcard_best : 11'sd0;
          i = (identity_best >= 0) ? identity_best :
              (wildcard_best == 0) ? 11'sd0 : 11'sd1000;
          if (!header_seen) verdict.coding = ane_pkg::CODING_IDENTITY;
          else if (g == 0 && i == 0) verdict.coding = ane_pkg::CODING_NONE;
          else if (g > 0 && g >= i) verdict.coding = ane_pkg::CODING_GZIP;
          else verdict.coding = ane_pkg::CODING_IDENTITY;
          verdict.gzip_quality = g[9:0];
          verdict.identity_quality = i[9:0];
          pending_decisions = {pending_decisions, verdict};
          restart();
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, logic [9:0] want, logic [9:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_decision(ane_pkg::out_item_t got);
      ane_pkg::out_item_t want;
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected decision, expected none, got coding %0d q %0d/%0d",
                 $time, got.coding, got.gzip_quality, got.identity_quality);
        errors++;
        return;
      end
      want = pending_decisions.pop_front();
      compare_field("coding", 10'(want.coding), 10'(got.coding));
      compare_field("gzip_quality", want.gzip_quality, got.gzip_quality);
      compare_field("identity_quality", want.identity_quality, got.identity_quality);
    endfunction
  endclass

  negotiation_checker model;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && !out_stall_i) model.check_decision(out_data_o);
      if (in_valid_i && !in_stall_o) model.absorb_transfer(in_data_i);
    end
  end

  task automatic send_item(ane_pkg::in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_byte(bit [7:0] b);
    ane_pkg::in_item_t it;
    it.command = ane_pkg::CMD_BYTE;
    it.data_byte = b;
    send_item(it);
  endtask

  // The data byte rides along with a command but is ignored.
  task automatic send_cmd(logic [1:0] command);
    ane_pkg::in_item_t it;
    it.command = command;
    it.data_byte = 8'($urandom_range(255));
    send_item(it);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  function automatic string blanks();
    case ($urandom_range(9))
      0: return " ";
      1: return "\t";
      2: return " \t ";
      default: return "";
    endcase
  endfunction

  function automatic string mixed_case(string w);
    string s;
    bit [7:0] c;
    s = w;
    for (int k = 0; k < s.len(); k++) begin
      c = s[k];
      if (c >= "a" && c <= "z" && $urandom_range(1) == 1) s[k] = c - 8'd32;
    end
    return s;
  endfunction

  function automatic string quality_text();
    string digits;
    digits = "";
    case ($urandom_range(19))
      0: return "1";
      1: return "1.";
      2: return "1.0";
      3: return "1.00";
      4: return "1.000";
      5: return "0";
      6: return "0.";
      7, 8, 9, 10, 11: begin
        repeat ($urandom_range(1, 3)) digits = {digits, $sformatf("%0d", $urandom_range(9))};
        return {"0.", digits};
      end
      12: return "1.0000";
      13: return "0.1234";
      14: return "2";
      15: return "1.5";
      16: return ".5";
      17: return "0.5x";
      18: return "";
      default: return "0 .5";
    endcase
  endfunction

  function automatic string param_text();
    case ($urandom_range(13))
      0: return "a=b";
      1: return "";
      2: return " ";
      3: return "q";
      4: return "q 1";
      5: return "q==1";
      default: return {blanks(), mixed_case("q"), blanks(), "=", blanks(),
                       quality_text(), blanks()};
    endcase
  endfunction

  function automatic string coding_text();
    case ($urandom_range(13))
      0, 1, 2, 3: return mixed_case("gzip");
      4, 5, 6: return mixed_case("identity");
      7, 8: return "*";
      9: return "";
      10: begin
        case ($urandom_range(3))
          0: return "gzi";
          1: return "gzipp";
          2: return "identit";
          default: return "identityy";
        endcase
      end
      11: return ($urandom_range(1) == 1) ? "gz ip" : "* x";
      12: return ($urandom_range(1) == 1) ? "**" : "x";
      default: return "x-gzip";
    endcase
  endfunction

  function automatic string item_text();
    string s;
    s = {blanks(), coding_text(), blanks()};
    repeat ($urandom_range(0, 2)) s = {s, ";", param_text()};
    if ($urandom_range(5) == 0) s = {s, ";", blanks()};
    return s;
  endfunction

  function automatic string field_text();
    string s;
    s = item_text();
    repeat ($urandom_range(0, 2)) s = {s, ",", item_text()};
    return s;
  endfunction

  // Mostly well-formed requests; one in ten is raw noise with stray commands.
  task automatic send_request();
    ane_pkg::in_item_t it;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 20)) begin
        it.command = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : ane_pkg::CMD_BYTE;
        it.data_byte = 8'($urandom_range(255));
        send_item(it);
      end
    end else begin
      repeat ($urandom_range(0, 3)) begin
        send_text(field_text());
        send_cmd(ane_pkg::CMD_FIELD_END);
      end
      if ($urandom_range(7) == 0) send_text(field_text());
    end
    send_cmd(ane_pkg::CMD_DECIDE);
  endtask

  task automatic run_stimulus();
    sender_idle_pct = 8;
    receiver_stall_pct = 79;

    send_cmd(ane_pkg::CMD_DECIDE);
    send_cmd(ane_pkg::CMD_FIELD_END);
    send_cmd(ane_pkg::CMD_DECIDE);
    send_text("*;q=0");
    send_cmd(ane_pkg::CMD_FIELD_END);
    send_cmd(ane_pkg::CMD_DECIDE);
    send_cmd(CMD_UNUSED);
    send_text("GZIP ; q= 1.0;");
    send_cmd(ane_pkg::CMD_FIELD_END);
    // Bytes after the last field end are dropped at the decision.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_cmd(ane_pkg::CMD_DECIDE);

    while (bytes_sent < HEADER_BYTES) begin
      if (bytes_sent < HEADER_BYTES / 3) begin
        sender_idle_pct = 8;
        receiver_stall_pct = 79;
      end else if (bytes_sent < 2 * HEADER_BYTES / 3) begin
        sender_idle_pct = 79;
        receiver_stall_pct = 8;
      end else begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      send_request();
    end
    in_valid_i <= 1'b0;
    receiver_stall_pct = 0;
    while (model.pending_decisions.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    model = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    fork
      run_stimulus();
      begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        timed_out = 1'b1;
      end
    join_any
    disable fork;
    if (!timed_out && model.errors == 0 && model.pending_decisions.size() == 0) begin
      $display("[accept_encoding_negotiator] OK");
    end else begin
      $display("[accept_encoding_negotiator] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ane_pkg.sv
src/accept_encoding_negotiator.sv
src/ane_checker.sv
sim/tb_accept_encoding_negotiator.sv
